// ===== design/assert_macros.svh =====
// assertion helpers used by the port-level checker
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked property, ignored while reset is low
`define ASSERT_CLK(label, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");

// implication checked in the following cycle
`define ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ===== design/arot_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// arot_pkg
// shared constants, types and tables of the axis-angle point rotator
// ----------------------------------------------------------------------------
package arot_pkg;

    localparam int COORD_WIDTH  = 32;
    localparam int CORDIC_STEPS = 16;
    localparam int STEP_W       = $clog2(CORDIC_STEPS);

    localparam int ANGLE_W   = 16;
    localparam int MODE_W    = 2;
    localparam int AXIS_W    = 16;
    localparam int CFG_W     = 16;
    localparam int CFG_IDX_W = 3;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_ANGLE  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MODE   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_AXIS_X = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_AXIS_Y = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_AXIS_Z = 3'd4;

    // axis modes
    localparam logic [MODE_W-1:0] MODE_X      = 2'd0;
    localparam logic [MODE_W-1:0] MODE_Y      = 2'd1;
    localparam logic [MODE_W-1:0] MODE_Z      = 2'd2;
    localparam logic [MODE_W-1:0] MODE_CUSTOM = 2'd3;

    // full-scale axis components can push a custom coefficient past 2^27
    localparam int COEF_FRAC = 24;
    localparam int COEF_W    = 29;
    localparam int CORD_W    = 34;
    localparam logic signed [CORD_W-1:0] CORDIC_GAIN_INV = 34'sd652032874;

    localparam int PROD_W = COORD_WIDTH + COEF_W;
    localparam int SUM_W  = PROD_W + 2;
    localparam int RND_W  = SUM_W - COEF_FRAC;
    localparam int DATA_W = 4 * COORD_WIDTH;

    typedef logic signed [COEF_W-1:0] coef_t;
    typedef coef_t [8:0] coef_mat_t;

    typedef struct packed {
        logic      ready;
        coef_mat_t mat;
    } mat_bus_t;

    function automatic logic signed [CORD_W-1:0] atan_lut(input logic [4:0] i);
        logic signed [CORD_W-1:0] v;
        case (i)
            5'd0:    v = 34'sh20000000;
            5'd1:    v = 34'sh12E4051E;
            5'd2:    v = 34'sh09FB385B;
            5'd3:    v = 34'sh051111D4;
            5'd4:    v = 34'sh028B0D43;
            5'd5:    v = 34'sh0145D7E1;
            5'd6:    v = 34'sh00A2F61E;
            5'd7:    v = 34'sh00517C55;
            5'd8:    v = 34'sh0028BE53;
            5'd9:    v = 34'sh00145F2F;
            5'd10:   v = 34'sh000A2F98;
            5'd11:   v = 34'sh000517CC;
            5'd12:   v = 34'sh00028BE6;
            5'd13:   v = 34'sh000145F3;
            5'd14:   v = 34'sh0000A2FA;
            5'd15:   v = 34'sh0000517D;
            5'd16:   v = 34'sh000028BE;
            5'd17:   v = 34'sh0000145F;
            5'd18:   v = 34'sh00000A30;
            5'd19:   v = 34'sh00000518;
            5'd20:   v = 34'sh0000028C;
            5'd21:   v = 34'sh00000146;
            5'd22:   v = 34'sh000000A3;
            5'd23:   v = 34'sh00000051;
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage
`default_nettype wire

// ===== design/arot_cfg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// arot_cfg
// configuration registers and rotation matrix builder (iterative cordic)
// ----------------------------------------------------------------------------
module arot_cfg
(
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           cfg_we,
    input  wire logic [arot_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [arot_pkg::CFG_W-1:0]     cfg_data,
    output arot_pkg::mat_bus_t                  mat_bus
);

    typedef enum logic [2:0] {ST_LOAD, ST_ROT, ST_FOLD, ST_PROD, ST_COEF, ST_DONE} state_t;

    localparam int US_W = arot_pkg::AXIS_W + arot_pkg::COEF_W;
    localparam logic signed [arot_pkg::COEF_W-1:0] ONE =
        arot_pkg::COEF_W'(1 << arot_pkg::COEF_FRAC);
    localparam logic signed [US_W-1:0] K_HALF = US_W'(8192);

    state_t                                  state_reg;
    logic [arot_pkg::ANGLE_W-1:0]            angle_reg;
    logic [arot_pkg::MODE_W-1:0]             mode_reg;
    logic signed [arot_pkg::AXIS_W-1:0]      ax_reg [3];
    logic [arot_pkg::STEP_W-1:0]             step_reg;
    logic [1:0]                              quad_reg;
    logic signed [arot_pkg::CORD_W-1:0]      x_reg, y_reg, z_reg;
    logic signed [arot_pkg::COEF_W-1:0]      c_reg, s_reg;
    logic signed [2*arot_pkg::AXIS_W-1:0]    uu_reg [9];
    logic signed [arot_pkg::COEF_W-1:0]      k_reg [3];
    logic signed [arot_pkg::COEF_W:0]        t_reg;
    arot_pkg::coef_mat_t                     mat_reg;

    logic [arot_pkg::ANGLE_W:0]              angle_ofs;
    logic [1:0]                              quad;
    logic [arot_pkg::ANGLE_W-1:0]            resid;
    logic signed [arot_pkg::CORD_W-1:0]      dx, dy;
    logic signed [arot_pkg::COEF_W-1:0]      c_raw, s_raw;
    logic signed [arot_pkg::COEF_W-1:0]      c_next, s_next;
    logic signed [US_W-1:0]                  us [3];
    logic signed [63:0]                      uut [9];
    arot_pkg::coef_mat_t                     mat_next;

    // quadrant fold of the binary angle
    assign angle_ofs = {1'b0, angle_reg} + 17'h2000;
    assign quad      = angle_ofs[15:14];
    assign resid     = angle_reg - {quad, 14'h0};

    assign dx = y_reg >>> step_reg;
    assign dy = x_reg >>> step_reg;

    always_comb
    begin
        c_raw = arot_pkg::COEF_W'((x_reg + 34'sd32) >>> 6);
        s_raw = arot_pkg::COEF_W'((y_reg + 34'sd32) >>> 6);
        case (quad_reg)
            2'd0:    begin c_next = c_raw;  s_next = s_raw;  end
            2'd1:    begin c_next = -s_raw; s_next = c_raw;  end
            2'd2:    begin c_next = -c_raw; s_next = -s_raw; end
            default: begin c_next = s_raw;  s_next = -c_raw; end
        endcase
    end

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            us[i] = ax_reg[i] * s_reg;
        end
        for (int i = 0; i < 9; i++)
        begin
            uut[i] = 64'(uu_reg[i]) * 64'(t_reg) + 64'sd134217728;
        end
    end

    always_comb
    begin
        mat_next = '0;
        unique case (mode_reg)
            arot_pkg::MODE_X:
            begin
                mat_next[0] = ONE;   mat_next[4] = c_reg; mat_next[5] = -s_reg;
                mat_next[7] = s_reg; mat_next[8] = c_reg;
            end
            arot_pkg::MODE_Y:
            begin
                mat_next[0] = c_reg;  mat_next[2] = s_reg; mat_next[4] = ONE;
                mat_next[6] = -s_reg; mat_next[8] = c_reg;
            end
            arot_pkg::MODE_Z:
            begin
                mat_next[0] = c_reg; mat_next[1] = -s_reg; mat_next[3] = s_reg;
                mat_next[4] = c_reg; mat_next[8] = ONE;
            end
            default:
            begin
                for (int i = 0; i < 9; i++)
                begin
                    mat_next[i] = arot_pkg::COEF_W'(uut[i] >>> 28);
                end
                mat_next[0] = mat_next[0] + c_reg;
                mat_next[4] = mat_next[4] + c_reg;
                mat_next[8] = mat_next[8] + c_reg;
                mat_next[1] = mat_next[1] - k_reg[2];
                mat_next[3] = mat_next[3] + k_reg[2];
                mat_next[2] = mat_next[2] + k_reg[1];
                mat_next[6] = mat_next[6] - k_reg[1];
                mat_next[5] = mat_next[5] - k_reg[0];
                mat_next[7] = mat_next[7] + k_reg[0];
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_LOAD;
            angle_reg <= '0;
            mode_reg  <= '0;
            ax_reg    <= '{default: '0};
            step_reg  <= '0;
            quad_reg  <= '0;
            x_reg     <= '0;
            y_reg     <= '0;
            z_reg     <= '0;
            c_reg     <= '0;
            s_reg     <= '0;
            uu_reg    <= '{default: '0};
            k_reg     <= '{default: '0};
            t_reg     <= '0;
            mat_reg   <= '0;
        end
        else
        begin
            unique case (state_reg)
                ST_LOAD:
                begin
                    x_reg     <= arot_pkg::CORDIC_GAIN_INV;
                    y_reg     <= '0;
                    z_reg     <= {{2{resid[15]}}, resid, 16'h0};
                    quad_reg  <= quad;
                    step_reg  <= '0;
                    state_reg <= ST_ROT;
                end
                ST_ROT:
                begin
                    // ties at zero rotate positively
                    if (!z_reg[arot_pkg::CORD_W-1])
                    begin
                        x_reg <= x_reg - dx;
                        y_reg <= y_reg + dy;
                        z_reg <= z_reg - arot_pkg::atan_lut(5'(step_reg));
                    end
                    else
                    begin
                        x_reg <= x_reg + dx;
                        y_reg <= y_reg - dy;
                        z_reg <= z_reg + arot_pkg::atan_lut(5'(step_reg));
                    end
                    step_reg <= step_reg + 1'b1;
                    if (step_reg == arot_pkg::STEP_W'(arot_pkg::CORDIC_STEPS - 1))
                    begin
                        state_reg <= ST_FOLD;
                    end
                end
                ST_FOLD:
                begin
                    c_reg     <= c_next;
                    s_reg     <= s_next;
                    state_reg <= ST_PROD;
                end
                ST_PROD:
                begin
                    for (int i = 0; i < 3; i++)
                    begin
                        for (int j = 0; j < 3; j++)
                        begin
                            uu_reg[i*3+j] <= ax_reg[i] * ax_reg[j];
                        end
                        k_reg[i] <= arot_pkg::COEF_W'((us[i] + K_HALF) >>> 14);
                    end
                    t_reg     <= {ONE[arot_pkg::COEF_W-1], ONE} - {c_reg[arot_pkg::COEF_W-1], c_reg};
                    state_reg <= ST_COEF;
                end
                ST_COEF:
                begin
                    mat_reg   <= mat_next;
                    state_reg <= ST_DONE;
                end
                default:
                begin
                    state_reg <= ST_DONE;
                end
            endcase

            if (cfg_we)
            begin
                state_reg <= ST_LOAD;
                case (cfg_index)
                    arot_pkg::REG_ANGLE:  angle_reg <= cfg_data;
                    arot_pkg::REG_MODE:   mode_reg  <= cfg_data[arot_pkg::MODE_W-1:0];
                    arot_pkg::REG_AXIS_X: ax_reg[0] <= cfg_data;
                    arot_pkg::REG_AXIS_Y: ax_reg[1] <= cfg_data;
                    arot_pkg::REG_AXIS_Z: ax_reg[2] <= cfg_data;
                    default: ;
                endcase
            end
        end
    end

    assign mat_bus.ready = (state_reg == ST_DONE);
    assign mat_bus.mat   = mat_reg;

endmodule
`default_nettype wire

// ===== design/arot_mac.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// arot_mac
// four-stage matrix times point pipeline with rounding and saturation
// ----------------------------------------------------------------------------
module arot_mac
(
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             en,
    input  wire logic                             in_valid,
    input  wire logic [arot_pkg::DATA_W-1:0]      in_data,
    input  arot_pkg::coef_mat_t                   mat,
    output logic                                  out_valid,
    output logic [arot_pkg::DATA_W-1:0]           out_data,
    output logic                                  out_clip
);

    localparam int CW = arot_pkg::COORD_WIDTH;
    localparam logic signed [arot_pkg::RND_W-1:0] HI_LIM =
        arot_pkg::RND_W'({1'b0, {(CW-1){1'b1}}});
    localparam logic signed [arot_pkg::RND_W-1:0] LO_LIM =
        -HI_LIM - arot_pkg::RND_W'(1);
    localparam logic signed [arot_pkg::SUM_W-1:0] HALF =
        arot_pkg::SUM_W'(1) <<< (arot_pkg::COEF_FRAC - 1);

    logic [3:0]                          v_reg;
    logic signed [CW-1:0]                p_reg [3];
    logic signed [CW-1:0]                w1_reg, w2_reg, w3_reg;
    logic signed [arot_pkg::PROD_W-1:0]  prod_reg [9];
    logic signed [arot_pkg::SUM_W-1:0]   sum_reg [3];
    logic [arot_pkg::DATA_W-1:0]         out_reg;
    logic                                clip_reg;

    logic signed [arot_pkg::RND_W-1:0]   rnd [3];
    logic signed [CW-1:0]                sat [3];
    logic [2:0]                          hit;

    always_comb
    begin
        for (int r = 0; r < 3; r++)
        begin
            rnd[r] = arot_pkg::RND_W'((sum_reg[r] + HALF) >>> arot_pkg::COEF_FRAC);
            if (rnd[r] > HI_LIM)
            begin
                sat[r] = CW'(HI_LIM);
                hit[r] = 1'b1;
            end
            else if (rnd[r] < LO_LIM)
            begin
                sat[r] = CW'(LO_LIM);
                hit[r] = 1'b1;
            end
            else
            begin
                sat[r] = CW'(rnd[r]);
                hit[r] = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else if (en)
        begin
            v_reg <= {v_reg[2:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k < 3; k++)
            begin
                p_reg[k] <= in_data[k*CW +: CW];
            end
            w1_reg <= in_data[3*CW +: CW];
            for (int r = 0; r < 3; r++)
            begin
                for (int k = 0; k < 3; k++)
                begin
                    prod_reg[r*3+k] <= p_reg[k] * $signed(mat[r*3+k]);
                end
            end
            w2_reg <= w1_reg;
            for (int r = 0; r < 3; r++)
            begin
                sum_reg[r] <= arot_pkg::SUM_W'(prod_reg[r*3])
                            + arot_pkg::SUM_W'(prod_reg[r*3+1])
                            + arot_pkg::SUM_W'(prod_reg[r*3+2]);
            end
            w3_reg   <= w2_reg;
            out_reg  <= {w3_reg, sat[2], sat[1], sat[0]};
            clip_reg <= |hit;
        end
    end

    assign out_valid = v_reg[3];
    assign out_data  = out_reg;
    assign out_clip  = clip_reg;

endmodule
`default_nettype wire

// ===== design/axis_angle_point_rotator_core.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// axis_angle_point_rotator_core
// rotates homogeneous points by a configured angle about x, y, z or an axis
// ----------------------------------------------------------------------------
// Takes one point per clock while s_tready is high; an accepted item passes
// the input, multiply, row sum and round/saturate registers before m_tvalid
// rises. All stages advance together and hold when the output is stalled.
// After reset and after every configuration write the matrix builder reruns
// its iterative cordic (one step per cycle) and the coefficient products, so
// s_tready stays low until the new matrix is ready.
module axis_angle_point_rotator_core
(
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             s_tvalid,
    output logic                                  s_tready,
    input  wire logic [arot_pkg::DATA_W-1:0]      s_tdata,  // point_x, point_y, point_z, point_w
    output logic                                  m_tvalid,
    input  wire logic                             m_tready,
    output logic [arot_pkg::DATA_W-1:0]           m_tdata,  // rotated_x, y, z, w
    output logic                                  m_tuser,  // clipped
    input  wire logic                             cfg_we,
    input  wire logic [arot_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [arot_pkg::CFG_W-1:0]       cfg_data
);

    arot_pkg::mat_bus_t mat_bus;
    logic               en;

    arot_cfg u_cfg
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .mat_bus   (mat_bus)
    );

    // whole pipeline moves when the output slot is free or being taken
    assign en       = !m_tvalid || m_tready;
    assign s_tready = en && mat_bus.ready;

    arot_mac u_mac
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (s_tvalid && s_tready),
        .in_data   (s_tdata),
        .mat       (mat_bus.mat),
        .out_valid (m_tvalid),
        .out_data  (m_tdata),
        .out_clip  (m_tuser)
    );

endmodule
`default_nettype wire

// ===== design/arot_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
// ----------------------------------------------------------------------------
// arot_checker
// port-level checks of the point rotator
// ----------------------------------------------------------------------------
module arot_checker
(
    input wire logic                             clk,
    input wire logic                             rst_n,
    input wire logic                             s_tready,
    input wire logic                             m_tvalid,
    input wire logic                             m_tready,
    input wire logic [arot_pkg::DATA_W-1:0]      m_tdata,
    input wire logic                             m_tuser,
    input wire logic                             cfg_we
);

    localparam int CW = arot_pkg::COORD_WIDTH;
    localparam logic [CW-1:0] MAXV = {1'b0, {(CW-1){1'b1}}};
    localparam logic [CW-1:0] MINV = {1'b1, {(CW-1){1'b0}}};

    // matrix rebuild blocks input right after a write
    `ASSERT_NEXT(a_cfg_blocks, cfg_we, !s_tready)

    // stalled result holds
    `ASSERT_NEXT(a_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser))

    // a clipped item carries a rail value
    `ASSERT_CLK(a_clip_rail, m_tvalid && m_tuser |->
        (m_tdata[CW-1:0] == MAXV || m_tdata[CW-1:0] == MINV ||
         m_tdata[2*CW-1:CW] == MAXV || m_tdata[2*CW-1:CW] == MINV ||
         m_tdata[3*CW-1:2*CW] == MAXV || m_tdata[3*CW-1:2*CW] == MINV))

    // no input taken while the output is stalled
    `ASSERT_CLK(a_stall_in, m_tvalid && !m_tready |-> !s_tready)

endmodule

bind axis_angle_point_rotator_core arot_checker u_arot_checker (.*);
`default_nettype wire
